### hdl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared widths, op and result codes, and the queued item type of the
// code tree decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

   // field widths of the request and response beats
   localparam int OP_W   = 2;
   localparam int SYM_W  = 8;
   localparam int CODE_W = 16;
   localparam int CB_W   = $clog2(CODE_W);
   localparam int LEN_W  = 5;
   localparam int IDX_W  = 9;
   localparam int KIND_W = 2;
   localparam int VT_W   = 16;

   // defaults of the top level parameters
   localparam int DEF_MAX_NODES    = 512;
   localparam int DEF_MAX_CODE_LEN = 16;
   localparam int DEF_COUNT_WIDTH  = 16;

   // entries of the queue between front and engine (power of two)
   localparam int QUEUE_DEPTH = 2;

   // request ops
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MISS   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FULL   = 2'd3;

   // classified item as it waits in the queue
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;   // already clamped
      logic              stream_bit;
      logic [IDX_W-1:0]  node_index;
      logic              idx_ok;        // node_index below the store size
   } htd_item_type;

endpackage

`default_nettype wire

### hdl/htd_front.sv
// ----------------------------------------------------------------------------
// htd_front
// Request side: takes beats, drops unknown ops, clamps the codeword length,
// flags out-of-range node reads and queues the items for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_front
   import htd_pkg::*;
#(
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [CODE_W-1:0] req_code_bits,
   input  wire logic [LEN_W-1:0]  req_code_length,
   input  wire logic              req_stream_bit,
   input  wire logic [IDX_W-1:0]  req_node_index,
   output htd_item_type           head_item,
   output logic                   head_valid,
   input  wire logic              head_pop
);

   localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);

   htd_item_type           item_in;
   htd_item_type           q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic                   known_op;
   logic                   push;

   // classify the incoming beat
   always_comb begin
      item_in.op          = req_op;
      item_in.symbol      = req_symbol;
      item_in.code_bits   = req_code_bits;
      item_in.code_length = (req_code_length > LEN_W'(LEN_LIMIT)) ?
                            LEN_W'(LEN_LIMIT) : req_code_length;
      item_in.stream_bit  = req_stream_bit;
      item_in.node_index  = req_node_index;
      item_in.idx_ok      = (32'(req_node_index) < 32'(MAX_NODES));
   end

   assign known_op  = req_op inside {OP_INSERT, OP_DECODE, OP_READ};
   assign req_ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   // unknown ops are taken and dropped
   assign push      = req_valid && req_ready && known_op;

   assign head_valid = (fill_ff != '0);
   assign head_item  = q_mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && head_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

### hdl/htd_engine.sv
// ----------------------------------------------------------------------------
// htd_engine
// Back end: holds the node store, runs inserts one codeword bit a cycle,
// steps the decode walk, serves node reads and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_engine
   import htd_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire htd_item_type      head_item,
   input  wire logic              head_valid,
   output logic                   head_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [SYM_W-1:0]       rsp_decoded_symbol,
   output logic [VT_W-1:0]        rsp_visit_total,
   output logic [IDX_W-1:0]       rsp_left_index,
   output logic [IDX_W-1:0]       rsp_right_index
);

   localparam int IW  = $clog2(MAX_NODES);
   localparam int NFW = $clog2(MAX_NODES + 1);
   localparam int CW  = COUNT_WIDTH;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_INS_STEP  = 3'd1;
   localparam logic [2:0] ST_DEC_LOAD  = 3'd2;
   localparam logic [2:0] ST_DEC_CHILD = 3'd3;
   localparam logic [2:0] ST_RD_WAIT   = 3'd4;

   // node store; entry 0 unused, the root lives in flops
   logic [2*IW-1:0]   link_mem [MAX_NODES];
   logic [CW-1:0]     cnt_mem  [MAX_NODES];
   logic [SYM_W-1:0]  sym_mem  [MAX_NODES];

   logic [2:0]        state_ff, state_in;
   logic [NFW-1:0]    nf_ff, nf_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     cache_l_ff, cache_l_in;
   logic [IW-1:0]     cache_r_ff, cache_r_in;
   logic              cache_v_ff, cache_v_in;
   logic [IW-1:0]     n_ff, n_in;
   logic              fresh_ff, fresh_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [IW-1:0]     root_l_ff, root_l_in;
   logic [IW-1:0]     root_r_ff, root_r_in;
   logic [CW-1:0]     root_cnt_ff, root_cnt_in;
   logic [SYM_W-1:0]  root_sym_ff, root_sym_in;

   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     rd_addr_ff;
   logic [2*IW-1:0]   rd_link_ff;
   logic [CW-1:0]     rd_cnt_ff;
   logic [SYM_W-1:0]  rd_sym_ff;
   logic [IW-1:0]     rd_l, rd_r;

   logic              lk_we, cn_we, sy_we;
   logic [IW-1:0]     lk_wa, cn_wa, sy_wa;
   logic [2*IW-1:0]   lk_wd;
   logic [CW-1:0]     cn_wd;
   logic [SYM_W-1:0]  sy_wd;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [SYM_W-1:0]  rsp_sym_ff;
   logic [VT_W-1:0]   rsp_vt_ff;
   logic [IDX_W-1:0]  rsp_l_ff, rsp_r_ff;
   logic              rsp_free;
   logic              emit;
   logic [KIND_W-1:0] emit_kind;
   logic [SYM_W-1:0]  emit_sym;
   logic [VT_W-1:0]   emit_vt;
   logic [IDX_W-1:0]  emit_l, emit_r;

   logic [IW-1:0]     dec_l, dec_r, dec_child;
   logic              dec_go;
   logic [IW-1:0]     ins_l, ins_r, ins_link, ins_new_l, ins_new_r;
   logic              ins_b, ins_full;
   logic              ch_leaf;
   logic [IW-1:0]     rd_idx;

   // count helpers
   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
      sat_inc = (c == {CW{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [VT_W-1:0] sat_vt(input logic [CW-1:0] c);
      if ((c >> VT_W) != '0) begin
         sat_vt = '1;
      end else begin
         sat_vt = VT_W'(c);
      end
   endfunction

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rd_l     = rd_link_ff[2*IW-1:IW];
   assign rd_r     = rd_link_ff[IW-1:0];
   assign rd_idx   = IW'(head_item.node_index);

   // decode step: children of the current node
   assign dec_l     = (cur_ff == '0) ? root_l_ff :
                      ((state_ff == ST_DEC_LOAD) ? rd_l : cache_l_ff);
   assign dec_r     = (cur_ff == '0) ? root_r_ff :
                      ((state_ff == ST_DEC_LOAD) ? rd_r : cache_r_ff);
   assign dec_child = head_item.stream_bit ? dec_r : dec_l;

   // insert step: children of the walk node, fresh nodes have none
   assign ins_l     = (n_ff == '0) ? root_l_ff : (fresh_ff ? '0 : rd_l);
   assign ins_r     = (n_ff == '0) ? root_r_ff : (fresh_ff ? '0 : rd_r);
   assign ins_b     = head_item.code_bits[CB_W'(rem_ff - 1'b1)];
   assign ins_link  = ins_b ? ins_r : ins_l;
   assign ins_full  = (nf_ff >= NFW'(MAX_NODES));
   assign ins_new_l = ins_b ? ins_l : IW'(nf_ff);
   assign ins_new_r = ins_b ? IW'(nf_ff) : ins_r;

   assign ch_leaf = (rd_l == '0) && (rd_r == '0);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      nf_in       = nf_ff;
      cur_in      = cur_ff;
      cache_l_in  = cache_l_ff;
      cache_r_in  = cache_r_ff;
      cache_v_in  = cache_v_ff;
      n_in        = n_ff;
      fresh_in    = fresh_ff;
      rem_in      = rem_ff;
      root_l_in   = root_l_ff;
      root_r_in   = root_r_ff;
      root_cnt_in = root_cnt_ff;
      root_sym_in = root_sym_ff;
      head_pop    = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      lk_we       = 1'b0;
      lk_wa       = '0;
      lk_wd       = '0;
      cn_we       = 1'b0;
      cn_wa       = '0;
      cn_wd       = '0;
      sy_we       = 1'b0;
      sy_wa       = '0;
      sy_wd       = '0;
      emit        = 1'b0;
      emit_kind   = KIND_SYMBOL;
      emit_sym    = '0;
      emit_vt     = '0;
      emit_l      = '0;
      emit_r      = '0;
      dec_go      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head_item.op)
                  OP_INSERT: begin
                     // first insert into an empty tree names the root
                     if (nf_ff == NFW'(1) && root_l_ff == '0 && root_r_ff == '0) begin
                        root_sym_in = head_item.symbol;
                     end
                     n_in       = '0;
                     fresh_in   = 1'b0;
                     rem_in     = head_item.code_length;
                     cache_v_in = 1'b0;
                     state_in   = ST_INS_STEP;
                  end
                  OP_DECODE: begin
                     if (cur_ff != '0 && !cache_v_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_ff;
                        state_in = ST_DEC_LOAD;
                     end else if (dec_child != '0 || rsp_free) begin
                        if (cur_ff == '0) begin
                           root_cnt_in = sat_inc(root_cnt_ff);
                        end
                        dec_go = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (head_item.idx_ok && rd_idx != '0 && NFW'(rd_idx) < nf_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = rd_idx;
                        state_in = ST_RD_WAIT;
                     end else if (rsp_free) begin
                        // root, out of range or never allocated
                        emit      = 1'b1;
                        emit_kind = KIND_READ;
                        head_pop  = 1'b1;
                        if (head_item.idx_ok && rd_idx == '0) begin
                           emit_sym = root_sym_ff;
                           emit_vt  = sat_vt(root_cnt_ff);
                           emit_l   = IDX_W'(root_l_ff);
                           emit_r   = IDX_W'(root_r_ff);
                        end
                     end
                  end
                  default: begin
                     head_pop = 1'b1;
                  end
               endcase
            end
         end

         ST_INS_STEP: begin
            if (rem_ff == '0) begin
               // end of the path: store the symbol
               head_pop = 1'b1;
               state_in = ST_IDLE;
               if (n_ff == '0) begin
                  root_sym_in = head_item.symbol;
               end else begin
                  sy_we = 1'b1;
                  sy_wa = n_ff;
                  sy_wd = head_item.symbol;
               end
               if (fresh_ff) begin
                  lk_we = 1'b1;
                  lk_wa = n_ff;
                  cn_we = 1'b1;
                  cn_wa = n_ff;
               end
            end else if (ins_link != '0) begin
               // follow an existing branch
               rd_en    = 1'b1;
               rd_addr  = ins_link;
               n_in     = ins_link;
               fresh_in = 1'b0;
               rem_in   = rem_ff - 1'b1;
            end else if (ins_full) begin
               if (rsp_free) begin
                  emit      = 1'b1;
                  emit_kind = KIND_FULL;
                  head_pop  = 1'b1;
                  state_in  = ST_IDLE;
                  if (fresh_ff) begin
                     lk_we = 1'b1;
                     lk_wa = n_ff;
                     cn_we = 1'b1;
                     cn_wa = n_ff;
                     sy_we = 1'b1;
                     sy_wa = n_ff;
                     sy_wd = head_item.symbol;
                  end
               end
            end else begin
               // allocate the next free node under the walk node
               nf_in = nf_ff + 1'b1;
               if (n_ff == '0) begin
                  root_l_in = ins_new_l;
                  root_r_in = ins_new_r;
               end else begin
                  lk_we = 1'b1;
                  lk_wa = n_ff;
                  lk_wd = {ins_new_l, ins_new_r};
               end
               if (fresh_ff) begin
                  cn_we = 1'b1;
                  cn_wa = n_ff;
                  sy_we = 1'b1;
                  sy_wa = n_ff;
                  sy_wd = head_item.symbol;
               end
               n_in     = IW'(nf_ff);
               fresh_in = 1'b1;
               rem_in   = rem_ff - 1'b1;
            end
         end

         ST_DEC_LOAD: begin
            if (dec_child != '0 || rsp_free) begin
               dec_go = 1'b1;
            end
         end

         ST_DEC_CHILD: begin
            if (!ch_leaf || rsp_free) begin
               cn_we    = 1'b1;
               cn_wa    = rd_addr_ff;
               cn_wd    = sat_inc(rd_cnt_ff);
               head_pop = 1'b1;
               state_in = ST_IDLE;
               if (ch_leaf) begin
                  emit       = 1'b1;
                  emit_kind  = KIND_SYMBOL;
                  emit_sym   = rd_sym_ff;
                  cur_in     = '0;
                  cache_v_in = 1'b0;
               end else begin
                  cur_in     = rd_addr_ff;
                  cache_l_in = rd_l;
                  cache_r_in = rd_r;
                  cache_v_in = 1'b1;
               end
            end
         end

         ST_RD_WAIT: begin
            if (rsp_free) begin
               emit      = 1'b1;
               emit_kind = KIND_READ;
               emit_sym  = rd_sym_ff;
               emit_vt   = sat_vt(rd_cnt_ff);
               emit_l    = IDX_W'(rd_l);
               emit_r    = IDX_W'(rd_r);
               head_pop  = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // shared tail of a decode step
      if (dec_go) begin
         if (dec_child == '0) begin
            emit      = 1'b1;
            emit_kind = KIND_MISS;
            cur_in    = '0;
            head_pop  = 1'b1;
            state_in  = ST_IDLE;
         end else begin
            rd_en    = 1'b1;
            rd_addr  = dec_child;
            state_in = ST_DEC_CHILD;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         nf_ff       <= NFW'(1);
         cur_ff      <= '0;
         cache_v_ff  <= 1'b0;
         root_l_ff   <= '0;
         root_r_ff   <= '0;
         root_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         nf_ff       <= nf_in;
         cur_ff      <= cur_in;
         cache_v_ff  <= cache_v_in;
         root_l_ff   <= root_l_in;
         root_r_ff   <= root_r_in;
         root_cnt_ff <= root_cnt_in;
      end
   end

   // walk and cache payload
   always_ff @(posedge clock) begin
      cache_l_ff  <= cache_l_in;
      cache_r_ff  <= cache_r_in;
      n_ff        <= n_in;
      fresh_ff    <= fresh_in;
      rem_ff      <= rem_in;
      root_sym_ff <= root_sym_in;
   end

   // node store ports
   always_ff @(posedge clock) begin
      if (lk_we) begin
         link_mem[lk_wa] <= lk_wd;
      end
      if (cn_we) begin
         cnt_mem[cn_wa] <= cn_wd;
      end
      if (sy_we) begin
         sym_mem[sy_wa] <= sy_wd;
      end
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
         rd_link_ff <= link_mem[rd_addr];
         rd_cnt_ff  <= cnt_mem[rd_addr];
         rd_sym_ff  <= sym_mem[rd_addr];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_sym_ff  <= emit_sym;
         rsp_vt_ff   <= emit_vt;
         rsp_l_ff    <= emit_l;
         rsp_r_ff    <= emit_r;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_decoded_symbol = rsp_sym_ff;
   assign rsp_visit_total    = rsp_vt_ff;
   assign rsp_left_index     = rsp_l_ff;
   assign rsp_right_index    = rsp_r_ff;

   // checks
   a_nf_bound: assert property (@(posedge clock) disable iff (reset)
      (nf_ff != '0) && (nf_ff <= NFW'(MAX_NODES)))
      else $error("free pointer out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> rsp_free)
      else $error("response overwritten before taken");

   a_emit_pop: assert property (@(posedge clock) disable iff (reset)
      emit |-> (head_pop && head_valid))
      else $error("response without retiring an item");

   a_fresh_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_STEP && fresh_ff) |-> (n_ff != '0))
      else $error("root marked as freshly allocated");

endmodule

`default_nettype wire

### hdl/huffman_tree_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder_top
// Code tree Huffman decoder: codeword insert, bit-wise decode, node readout.
// ----------------------------------------------------------------------------
// Usage:
//  req_* is a valid/ready channel. Op 0 inserts a codeword, op 1 decodes one
//  stream bit, op 2 reads a node; op 3 is taken and dropped. rsp_* is a
//  valid/ready channel carrying at most one beat per request.
//  An accepted beat lands in a two-entry queue; an idle engine starts on it
//  the next cycle. Insert makes one store access per codeword bit and stops
//  early when the store runs out. Decode reads the child node, first
//  reloading the current node when an insert came in mid-codeword; a missing
//  branch needs no child read. A read of the root or of an unallocated node
//  needs no store access. Every store access goes through one read port
//  with registered data. The result is visible the cycle after the engine
//  finishes; the next item starts then.
//  A result sits in the output register until rsp_ready; items without a
//  result keep running, the queue fills up, then req_ready falls.
//  Reset (synchronous, active high) empties the tree at once: nodes at or
//  above the free pointer read as empty, so there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder_top
   import htd_pkg::*;
#(
   parameter int MAX_NODES    = DEF_MAX_NODES,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [SYM_W-1:0]  req_symbol,
   input  wire logic [CODE_W-1:0] req_code_bits,
   input  wire logic [LEN_W-1:0]  req_code_length,
   input  wire logic              req_stream_bit,
   input  wire logic [IDX_W-1:0]  req_node_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [SYM_W-1:0]       rsp_decoded_symbol,
   output logic [VT_W-1:0]        rsp_visit_total,
   output logic [IDX_W-1:0]       rsp_left_index,
   output logic [IDX_W-1:0]       rsp_right_index
);

   htd_item_type head_item;
   logic         head_valid;
   logic         head_pop;

   // accept and classify
   htd_front #(
      .MAX_NODES    (MAX_NODES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .req_stream_bit  (req_stream_bit),
      .req_node_index  (req_node_index),
      .head_item       (head_item),
      .head_valid      (head_valid),
      .head_pop        (head_pop)
   );

   // tree store and walk
   htd_engine #(
      .MAX_NODES   (MAX_NODES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .head_item          (head_item),
      .head_valid         (head_valid),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_decoded_symbol (rsp_decoded_symbol),
      .rsp_visit_total    (rsp_visit_total),
      .rsp_left_index     (rsp_left_index),
      .rsp_right_index    (rsp_right_index)
   );

endmodule

`default_nettype wire
